// ===== hw/rtl/rrt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the range remap table: sizes, opcodes, status codes and shared types.
// Has no dependencies. All other files of the block but rrt_ram import it.
package rrt_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned OffW         = 56;
  localparam int unsigned SizeW        = 32;
  localparam int unsigned DestW        = 64;
  localparam int unsigned BytesW       = 64;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 32;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_EXTEND   = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_OBSOLETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ORDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_COUNT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SRCH,
    BK_SRCH_CMP,
    BK_CHK_RD,
    BK_CHK,
    BK_APL_RD,
    BK_APL,
    BK_RESULT
  } back_state_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [OffW-1:0]   offset;
    logic [SizeW-1:0]  size;
    logic [DestW-1:0]  dest;
    logic [SizeW-1:0]  count;
  } cmd_t;

endpackage

// ===== hw/rtl/rrt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the remap table.
// Depends on rrt_pkg.
interface rrt_in_if;
  import rrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [OffW-1:0]   offset;
  logic [SizeW-1:0]  size;
  logic [DestW-1:0]  dest;
  logic [SizeW-1:0]  initial_count;

  modport source (output valid, op, offset, size, dest, initial_count, input ready);
  modport sink   (input valid, op, offset, size, dest, initial_count, output ready);
endinterface

interface rrt_out_if;
  import rrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [IdxW-1:0]   entry_index;
  logic [OffW-1:0]   entry_start;
  logic [SizeW-1:0]  entry_size;
  logic [DestW-1:0]  entry_dest;
  logic [SizeW-1:0]  entry_obsolete;
  logic [CntW-1:0]   count_now;
  logic [OffW-1:0]   limit_now;
  logic [BytesW-1:0] bytes_now;

  modport source (output valid, status, entry_index, entry_start, entry_size, entry_dest,
                  entry_obsolete, count_now, limit_now, bytes_now, input ready);
  modport sink   (input valid, status, entry_index, entry_start, entry_size, entry_dest,
                  entry_obsolete, count_now, limit_now, bytes_now, output ready);
endinterface

// ===== hw/rtl/rrt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rrt_front.sv =====
`timescale 1ns / 1ps
// Front of the remap table: accepts requests, resolves the initial count
// and queues them for the back. Depends on rrt_pkg and rrt_if.
module rrt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          keep_counts_i,
  rrt_in_if.sink        in_if,
  output rrt_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import rrt_pkg::*;

  cmd_t             queue_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] fill_q, fill_d;
  logic             push, pop;
  cmd_t             cmd_new;

  // Classify the incoming request.
  always_comb begin
    cmd_new.op     = op_e'(in_if.op);
    cmd_new.offset = in_if.offset;
    cmd_new.size   = in_if.size;
    cmd_new.dest   = in_if.dest;
    cmd_new.count  = keep_counts_i ? in_if.initial_count : '0;
  end

  assign in_if.ready = (fill_q != QCntW'(QueueDepth));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hw/rtl/rrt_back.sv =====
`timescale 1ns / 1ps
// Back of the remap table: table memories, search and walk sequencer, result register.
// Depends on rrt_pkg, rrt_if and rrt_ram.
module rrt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rrt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  rrt_out_if.source     out_if
);
  import rrt_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CntW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
  logic [IdxW-1:0]   first_q, first_d;
  logic [OffW-1:0]   pos_q, pos_d;
  logic [SizeW-1:0]  rest_q, rest_d, take_first_q, take_first_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [OffW-1:0]   limit_q, limit_d;
  logic [BytesW-1:0] bytes_q, bytes_d;

  status_e           res_status_q, res_status_d;
  logic [IdxW-1:0]   res_index_q, res_index_d;
  logic [OffW-1:0]   res_start_q, res_start_d;
  logic [SizeW-1:0]  res_size_q, res_size_d;
  logic [DestW-1:0]  res_dest_q, res_dest_d;
  logic [SizeW-1:0]  res_obs_q, res_obs_d;

  // Memory ports.
  logic              mem_re, mem_we_all, mem_we_obs;
  logic [IdxW-1:0]   mem_raddr, mem_waddr;
  logic [SizeW-1:0]  obs_wdata;
  logic [OffW-1:0]   rd_start;
  logic [SizeW-1:0]  rd_size, rd_obs;
  logic [DestW-1:0]  rd_dest;

  // Shared datapath terms.
  logic [CntW-1:0]   mid_c;
  logic [OffW:0]     app_end;
  logic [OffW-1:0]   key_inner, pos_inner;
  logic              pos_out;
  logic [SizeW-1:0]  avail, take;
  logic [SizeW:0]    obs_sum;
  logic [SizeW-1:0]  rest_new;
  logic [CntW-1:0]   idx_next;

  rrt_ram #(.Width(OffW), .Depth(TableEntries)) u_start_ram (
    .clk_i, .we_i(mem_we_all), .waddr_i(mem_waddr), .wdata_i(cmd_q.offset),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(rd_start));
  rrt_ram #(.Width(SizeW), .Depth(TableEntries)) u_size_ram (
    .clk_i, .we_i(mem_we_all), .waddr_i(mem_waddr), .wdata_i(cmd_q.size),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(rd_size));
  rrt_ram #(.Width(DestW), .Depth(TableEntries)) u_dest_ram (
    .clk_i, .we_i(mem_we_all), .waddr_i(mem_waddr), .wdata_i(cmd_q.dest),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(rd_dest));
  rrt_ram #(.Width(SizeW), .Depth(TableEntries)) u_obs_ram (
    .clk_i, .we_i(mem_we_all || mem_we_obs), .waddr_i(mem_waddr), .wdata_i(obs_wdata),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(rd_obs));

  // Search midpoint, append bound and the per-entry walk arithmetic.
  assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
  assign app_end   = {1'b0, cmd_q.offset} + {{(OffW + 1 - SizeW){1'b0}}, cmd_q.size};
  assign key_inner = cmd_q.offset - rd_start;
  assign pos_inner = pos_q - rd_start;
  assign pos_out   = (pos_q < rd_start) || (pos_inner >= {{(OffW - SizeW){1'b0}}, rd_size});
  assign avail     = rd_size - pos_inner[SizeW-1:0];
  assign take      = (rest_q < avail) ? rest_q : avail;
  assign obs_sum   = {1'b0, rd_obs} + {1'b0, take};
  assign rest_new  = rest_q - take;
  assign idx_next  = idx_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    idx_d        = idx_q;
    first_d      = first_q;
    pos_d        = pos_q;
    rest_d       = rest_q;
    take_first_d = take_first_q;
    used_d       = used_q;
    limit_d      = limit_q;
    bytes_d      = bytes_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_start_d  = res_start_q;
    res_size_d   = res_size_q;
    res_dest_d   = res_dest_q;
    res_obs_d    = res_obs_q;
    cmd_ready_o  = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[IdxW-1:0];
    mem_we_all   = 1'b0;
    mem_we_obs   = 1'b0;
    mem_waddr    = idx_q[IdxW-1:0];
    obs_wdata    = obs_sum[SizeW-1:0];

    case (state_q)
      // Take the next request and clear the reported entry.
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          res_status_d = ST_OK;
          res_index_d  = '0;
          res_start_d  = '0;
          res_size_d   = '0;
          res_dest_d   = '0;
          res_obs_d    = '0;
          lo_d         = '0;
          hi_d         = used_q;
          case (cmd_i.op)
            OP_APPEND:   state_d = BK_APL;
            OP_EXTEND:   state_d = BK_RESULT;
            OP_LOOKUP:   state_d = BK_SRCH;
            OP_OBSOLETE: state_d = BK_SRCH;
            default:     state_d = BK_RESULT;
          endcase
          if (cmd_i.op == OP_EXTEND) begin
            if (cmd_i.offset < limit_q) begin
              res_status_d = ST_ORDER;
            end else begin
              limit_d = cmd_i.offset;
            end
          end
          if (cmd_i.op == OP_APPEND) begin
            // Appends need no reads: check and write in the next cycle.
            idx_d   = used_q;
            state_d = BK_APL;
            rest_d  = '0;
          end
        end
      end

      // Binary search: issue the read at the midpoint or report a miss.
      BK_SRCH: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid_c[IdxW-1:0];
          mid_d     = mid_c;
          state_d   = BK_SRCH_CMP;
        end else begin
          res_status_d = ST_NOT_FOUND;
          state_d      = BK_RESULT;
        end
      end

      // Compare the key with the entry just read.
      BK_SRCH_CMP: begin
        if (cmd_q.offset < rd_start) begin
          hi_d    = mid_q;
          state_d = BK_SRCH;
        end else if (key_inner < {{(OffW - SizeW){1'b0}}, rd_size}) begin
          res_index_d  = mid_q[IdxW-1:0];
          res_start_d  = rd_start;
          res_size_d   = rd_size;
          res_dest_d   = rd_dest;
          res_obs_d    = rd_obs;
          first_d      = mid_q[IdxW-1:0];
          idx_d        = mid_q;
          pos_d        = cmd_q.offset;
          rest_d       = cmd_q.size;
          take_first_d = '0;
          state_d      = (cmd_q.op == OP_LOOKUP) ? BK_RESULT : BK_CHK;
        end else begin
          lo_d    = mid_q + 1'b1;
          state_d = BK_SRCH;
        end
      end

      // Check pass: read the next spanned entry.
      BK_CHK_RD: begin
        mem_re  = 1'b1;
        state_d = BK_CHK;
      end

      // Check pass: verify one entry, or start the apply pass when done (a zero size ends at the result).
      BK_CHK: begin
        if (rest_q == '0) begin
          if (cmd_q.size == '0) begin
            state_d = BK_RESULT;
          end else begin
            idx_d   = {{(CntW - IdxW){1'b0}}, first_q};
            pos_d   = cmd_q.offset;
            rest_d  = cmd_q.size;
            state_d = BK_APL_RD;
          end
        end else if (pos_out || (obs_sum > {1'b0, rd_size})) begin
          res_status_d = ST_COUNT;
          state_d      = BK_RESULT;
        end else begin
          if (idx_q[IdxW-1:0] == first_q) begin
            take_first_d = take;
          end
          pos_d  = pos_q + {{(OffW - SizeW){1'b0}}, take};
          rest_d = rest_new;
          idx_d  = idx_next;
          if (rest_new == '0) begin
            state_d = BK_CHK;
          end else if (idx_next >= used_q) begin
            res_status_d = ST_COUNT;
            state_d      = BK_RESULT;
          end else begin
            state_d = BK_CHK_RD;
          end
        end
      end

      // Apply pass: read the next spanned entry.
      BK_APL_RD: begin
        mem_re  = 1'b1;
        state_d = BK_APL;
      end

      // Apply pass step, or the checked append when the request is an append.
      BK_APL: begin
        if (cmd_q.op == OP_APPEND) begin
          if (used_q >= CntW'(TableEntries)) begin
            res_status_d = ST_FULL;
          end else if ((cmd_q.offset < limit_q) || app_end[OffW]) begin
            res_status_d = ST_ORDER;
          end else if (cmd_q.count >= cmd_q.size) begin
            res_status_d = ST_COUNT;
          end else begin
            mem_we_all  = 1'b1;
            obs_wdata   = cmd_q.count;
            used_d      = used_q + 1'b1;
            limit_d     = app_end[OffW-1:0];
            bytes_d     = bytes_q + {{(BytesW - SizeW){1'b0}}, cmd_q.size};
            res_index_d = used_q[IdxW-1:0];
            res_start_d = cmd_q.offset;
            res_size_d  = cmd_q.size;
            res_dest_d  = cmd_q.dest;
            res_obs_d   = cmd_q.count;
          end
          state_d = BK_RESULT;
        end else begin
          mem_we_obs = 1'b1;
          pos_d      = pos_q + {{(OffW - SizeW){1'b0}}, take};
          rest_d     = rest_new;
          idx_d      = idx_next;
          if (rest_new == '0) begin
            res_obs_d = res_obs_q + take_first_q;
            state_d   = BK_RESULT;
          end else begin
            state_d = BK_APL_RD;
          end
        end
      end

      // Hold the result until it is taken.
      BK_RESULT: begin
        if (out_if.ready) begin
          state_d = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      used_q  <= '0;
      limit_q <= '0;
      bytes_q <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      limit_q <= limit_d;
      bytes_q <= bytes_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    idx_q        <= idx_d;
    first_q      <= first_d;
    pos_q        <= pos_d;
    rest_q       <= rest_d;
    take_first_q <= take_first_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_start_q  <= res_start_d;
    res_size_q   <= res_size_d;
    res_dest_q   <= res_dest_d;
    res_obs_q    <= res_obs_d;
  end

  assign out_if.valid          = (state_q == BK_RESULT);
  assign out_if.status         = res_status_q;
  assign out_if.entry_index    = res_index_q;
  assign out_if.entry_start    = res_start_q;
  assign out_if.entry_size     = res_size_q;
  assign out_if.entry_dest     = res_dest_q;
  assign out_if.entry_obsolete = res_obs_q;
  assign out_if.count_now      = used_q;
  assign out_if.limit_now      = limit_q;
  assign out_if.bytes_now      = bytes_q;

endmodule

// ===== hw/rtl/range_remap_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the range remap table: configuration register, front queue and back sequencer.
// Depends on rrt_pkg, rrt_if, rrt_front, rrt_back and rrt_ram.
//
//   Channel  | Direction | Handshake               | Moves
//   in_if    | sink      | valid/ready             | one request: op, offset, size, dest, count
//   out_if   | source    | valid/ready             | one result per request
//   APB      | slave     | psel/penable, pready=1  | keep_initial_counts at byte address 0
//
// Extend goes from request to result through the result state alone; append passes the
// append check first, and each binary search step of a lookup has a read and a compare
// state. An obsolete add visits each spanned entry twice (one check read and one apply
// read with write-back); the single read port of the table memories sets these steps.
// Reset clears the entry count, limit and byte total; table contents are not cleared.
// The front queue takes up to two requests while the back works or a result waits.
module range_remap_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rrt_in_if.sink                       in_if,
  rrt_out_if.source                    out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrt_pkg::CfgAddrW-1:0] paddr,
  input  logic [rrt_pkg::CfgDataW-1:0] pwdata,
  output logic [rrt_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import rrt_pkg::*;

  logic keep_q, keep_d;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Configuration register.
  assign pready = 1'b1;
  always_comb begin
    keep_d = keep_q;
    if (psel && penable && pwrite && !paddr[2]) begin
      keep_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b1;
    end else begin
      keep_q <= keep_d;
    end
  end

  assign prdata = paddr[2] ? '0 : {{(CfgDataW - 1){1'b0}}, keep_q};

  rrt_front u_front (
    .clk_i,
    .rst_ni,
    .keep_counts_i (keep_q),
    .in_if         (in_if),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready)
  );

  rrt_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_if      (out_if)
  );

endmodule
